// ----- rtl/wstmo_pkg.sv -----
// Package for the wheel speed trimmed-mean odometer.
// Holds item types, register indexes, sequencer states and fixed constants.
// No dependencies.
package wstmo_pkg;

  localparam int RAW_W  = 24;  // Q16.8 speed
  localparam int DIV_DW = 47;  // shared divider dividend width
  localparam int DIV_SW = 32;  // shared divider divisor width

  localparam logic [24:0] KM_H_Q16        = 25'd18826345;
  localparam logic [15:0] PULSE_VALID_MIN = 16'd4;
  localparam logic [RAW_W-1:0] ALARM_SPEED_Q8 = 24'd512;
  localparam logic [RAW_W-1:0] Q8_MAX     = 24'hFFFFFF;

  localparam logic [5:0]  WHEEL_RST = 6'd14;
  localparam logic [7:0]  PPR_RST   = 8'd1;
  localparam logic [15:0] WIN_RST   = 16'd500;
  localparam logic [15:0] LIM_RST   = 16'd10;

  typedef enum logic [7:0] {
    REG_WHEEL_INCHES = 8'd0,
    REG_PULSES_PER_TURN = 8'd1,
    REG_WINDOW_MS = 8'd2,
    REG_ALARM_PULSE_LIMIT = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] pulse_count;
    logic        antitheft_armed;
  } in_item_t;

  typedef struct packed {
    logic [15:0] shown_speed_x10;
    logic [47:0] trip_distance;
    logic        rotation_alarm;
    logic        detect_done;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [15:0] data;
  } cfg_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_RING,
    S_LD,
    S_SQ,
    S_SQEND,
    S_VAR1,
    S_VAR2,
    S_UPD,
    S_DONE
  } state_e;

endpackage

// ----- rtl/wstmo_stream_if.sv -----
// Valid/ready channel interface carrying one typed item.
// Depends on nothing; the item type comes in as a type parameter.
interface wstmo_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/wheel_speed_trimmed_mean_odometer.sv -----
// Wheel speed trimmed-mean odometer, top level.
// Depends on wstmo_pkg and wstmo_stream_if.
//
// One item per counting window: pulse count and armed flag in, one result out.
// An item with more than four pulses goes through the multiply states, a raw-speed
// division and a ring sweep, plus a second division when the ring is steady enough
// to use the trimmed mean; other items go straight from idle to done. The time an
// item takes is set by the one shared restoring divider, which retires one quotient
// bit a cycle for both the raw speed and the trimmed mean, and by the ring sweep,
// which reads the entries one at a time through one squarer, loading each entry and
// then squaring it.
// The input is not ready while an item is in work; a finished result sits in
// an output register so the next item can be taken while it waits.
// Configuration writes are always accepted and must arrive while idle.
module wheel_speed_trimmed_mean_odometer
  import wstmo_pkg::*;
#(
  parameter int WINDOW_DEPTH = 7
) (
  input  logic clk_i,
  input  logic rst_ni,
  wstmo_stream_if.sink   cfg_i,
  wstmo_stream_if.sink   in_i,
  wstmo_stream_if.source out_o
);

  localparam int CW  = $clog2(WINDOW_DEPTH);
  localparam int S1W = RAW_W + CW;
  localparam int S2W = 2 * RAW_W + CW;
  localparam int VW  = 2 * S1W;
  localparam logic [VW-1:0] VAR_LIM = VW'(WINDOW_DEPTH * WINDOW_DEPTH * 65536);
  localparam logic [CW-1:0] LAST_IDX = CW'(WINDOW_DEPTH - 1);

  // configuration
  logic [5:0]  wheel_q;
  logic [7:0]  ppr_q;
  logic [15:0] win_q;
  logic [15:0] lim_q;

  cfg_item_t cfg_w;
  assign cfg_w = cfg_i.data;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_q <= WHEEL_RST;
      ppr_q   <= PPR_RST;
      win_q   <= WIN_RST;
      lim_q   <= LIM_RST;
    end else if (cfg_i.valid) begin
      case (cfg_w.index)
        REG_WHEEL_INCHES:      wheel_q <= cfg_w.data[5:0];
        REG_PULSES_PER_TURN:   ppr_q   <= cfg_w.data[7:0];
        REG_WINDOW_MS:         win_q   <= cfg_w.data;
        REG_ALARM_PULSE_LIMIT: lim_q   <= cfg_w.data;
        default: ;
      endcase
    end
  end

  // sequencer state and datapath registers
  state_e state_q, state_d;
  logic [RAW_W-1:0] ring_q [WINDOW_DEPTH];
  logic [RAW_W-1:0] ring_d [WINDOW_DEPTH];
  logic [CW-1:0]    pos_q, pos_d, idx_q, idx_d;
  logic [15:0]      shown_q, shown_d;
  logic [47:0]      dist_q, dist_d;
  logic [31:0]      atot_q, atot_d;
  logic [15:0]      pulses_q, pulses_d;
  logic [21:0]      pw_q, pw_d;
  logic [DIV_SW-1:0] dvs_q, dvs_d;
  logic [DIV_DW-1:0] dvd_q, dvd_d, quo_q, quo_d;
  logic [DIV_SW-1:0] rem_q, rem_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             trim_q, trim_d;
  logic [RAW_W-1:0] raw_q, raw_d, v_q, v_d, mn_q, mn_d, mx_q, mx_d, chosen_q, chosen_d;
  logic [2*RAW_W-1:0] sq_q, sq_d;
  logic [S1W-1:0]   s1_q, s1_d;
  logic [S2W-1:0]   s2_q, s2_d;
  logic [VW-1:0]    s1sq_q, s1sq_d;
  logic             alarm_q, alarm_d, done_q, done_d;
  out_item_t        out_q, out_d;
  logic             ovld_q, ovld_d;

  // shared divider step
  logic [DIV_SW:0]   rem_sh;
  logic              ge;
  logic [DIV_DW-1:0] quo_nx;
  assign rem_sh = {rem_q, dvd_q[DIV_DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign quo_nx = {quo_q[DIV_DW-2:0], ge};

  in_item_t in_w;
  assign in_w = in_i.data;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = ovld_q;
  assign out_o.data  = out_q;

  logic [32:0]    atot_sum;
  logic [31:0]    atot_sat;
  logic [VW-1:0]  var_diff;
  logic [S1W-1:0] trim_sum;
  logic [27:0]    x10;
  logic [7:0]     ppr_nz;
  logic [15:0]    win_nz;

  always_comb begin
    state_d = state_q;
    ring_d = ring_q;
    pos_d = pos_q; idx_d = idx_q;
    shown_d = shown_q; dist_d = dist_q; atot_d = atot_q;
    pulses_d = pulses_q; pw_d = pw_q;
    dvs_d = dvs_q; dvd_d = dvd_q; quo_d = quo_q; rem_d = rem_q;
    cnt_d = cnt_q; trim_d = trim_q;
    raw_d = raw_q; v_d = v_q; mn_d = mn_q; mx_d = mx_q; chosen_d = chosen_q;
    sq_d = sq_q; s1_d = s1_q; s2_d = s2_q; s1sq_d = s1sq_q;
    alarm_d = alarm_q; done_d = done_q;
    out_d = out_q;
    ovld_d = ovld_q && !out_o.ready;

    ppr_nz   = (ppr_q == 8'd0) ? 8'd1 : ppr_q;
    win_nz   = (win_q == 16'd0) ? 16'd1 : win_q;
    atot_sum = {1'b0, atot_q} + 33'(in_w.pulse_count);
    atot_sat = atot_sum[32] ? 32'hFFFFFFFF : atot_sum[31:0];
    var_diff = VW'(WINDOW_DEPTH) * VW'(s2_q) - s1sq_q;
    trim_sum = s1_q - S1W'(mn_q) - S1W'(mx_q);
    x10      = 28'(chosen_q) * 28'd10;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          pulses_d = in_w.pulse_count;
          alarm_d = 1'b0;
          done_d = 1'b0;
          if (in_w.pulse_count > PULSE_VALID_MIN) begin
            state_d = S_MUL1;
          end else begin
            if (in_w.antitheft_armed) begin
              done_d = 1'b1;
              if (atot_sat > 32'(lim_q)) begin
                atot_d = '0;
                alarm_d = 1'b1;
              end else begin
                atot_d = atot_sat;
              end
            end
            state_d = S_DONE;
          end
        end
      end
      S_MUL1: begin
        pw_d = 22'(pulses_q) * 22'(wheel_q);
        dvs_d = {24'(ppr_nz) * 24'(win_nz), 8'd0};
        state_d = S_MUL2;
      end
      S_MUL2: begin
        dvd_d = DIV_DW'(pw_q) * DIV_DW'(KM_H_Q16);
        rem_d = '0;
        quo_d = '0;
        cnt_d = 6'(DIV_DW);
        trim_d = 1'b0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = ge ? DIV_SW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIV_SW-1:0];
        dvd_d = {dvd_q[DIV_DW-2:0], 1'b0};
        quo_d = quo_nx;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          if (trim_q) begin
            chosen_d = quo_nx[RAW_W-1:0];
            state_d = S_UPD;
          end else begin
            raw_d = (quo_nx[DIV_DW-1:RAW_W] != '0) ? Q8_MAX : quo_nx[RAW_W-1:0];
            state_d = S_RING;
          end
        end
      end
      S_RING: begin
        ring_d[pos_q] = raw_q;
        pos_d = (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;
        idx_d = '0;
        s1_d = '0;
        s2_d = '0;
        sq_d = '0;
        mn_d = Q8_MAX;
        mx_d = '0;
        state_d = S_LD;
      end
      S_LD: begin
        v_d = ring_q[idx_q];
        s2_d = s2_q + S2W'(sq_q);
        state_d = S_SQ;
      end
      S_SQ: begin
        sq_d = v_q * v_q;
        s1_d = s1_q + S1W'(v_q);
        if (v_q < mn_q) mn_d = v_q;
        if (v_q > mx_q) mx_d = v_q;
        if (idx_q == LAST_IDX) begin
          state_d = S_SQEND;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = S_LD;
        end
      end
      S_SQEND: begin
        s2_d = s2_q + S2W'(sq_q);
        state_d = S_VAR1;
      end
      S_VAR1: begin
        s1sq_d = VW'(s1_q) * VW'(s1_q);
        state_d = S_VAR2;
      end
      S_VAR2: begin
        if (var_diff <= VAR_LIM) begin
          // steady ring: divide the trimmed sum, MSB aligned to save cycles
          dvd_d = DIV_DW'(trim_sum) << (DIV_DW - S1W);
          dvs_d = DIV_SW'(WINDOW_DEPTH - 2);
          rem_d = '0;
          quo_d = '0;
          cnt_d = 6'(S1W);
          trim_d = 1'b1;
          state_d = S_DIV;
        end else begin
          chosen_d = raw_q;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        shown_d = (x10[27:24] != 4'd0) ? 16'hFFFF : x10[23:8];
        dist_d = dist_q + 48'(chosen_q);
        if (raw_q > ALARM_SPEED_Q8) begin
          atot_d = '0;
          alarm_d = 1'b1;
        end
        done_d = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ovld_q || out_o.ready) begin
          out_d.shown_speed_x10 = shown_q;
          out_d.trip_distance = dist_q;
          out_d.rotation_alarm = alarm_q;
          out_d.detect_done = done_q;
          ovld_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < WINDOW_DEPTH; i++) ring_q[i] <= '0;
      pos_q   <= '0;
      shown_q <= '0;
      dist_q  <= '0;
      atot_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ring_q  <= ring_d;
      pos_q   <= pos_d;
      shown_q <= shown_d;
      dist_q  <= dist_d;
      atot_q  <= atot_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; pulses_q <= pulses_d; pw_q <= pw_d;
    dvs_q <= dvs_d; dvd_q <= dvd_d; quo_q <= quo_d; rem_q <= rem_d;
    cnt_q <= cnt_d; trim_q <= trim_d;
    raw_q <= raw_d; v_q <= v_d; mn_q <= mn_d; mx_q <= mx_d; chosen_q <= chosen_d;
    sq_q <= sq_d; s1_q <= s1_d; s2_q <= s2_d; s1sq_q <= s1sq_d;
    alarm_q <= alarm_d; done_q <= done_d;
    out_q <= out_d;
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LAST_IDX) else $error("ring position out of range");

  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cnt_q != 6'd0) else $error("divider ran with zero count");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q != S_IDLE) else $error("item accepted but idle");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovld_q) |-> $past(state_q == S_DONE)) else $error("result loaded outside done");
`endif

endmodule

// ----- tb/tb.sv -----
// Testbench for wheel_speed_trimmed_mean_odometer: random and directed windows,
// with results checked against a cycle-free predictor held in a scoreboard class.
// Depends on wstmo_pkg, wstmo_stream_if and the block itself.
module tb;
  import wstmo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 7;
  localparam logic [7:0] UNUSED_REG_INDEX = 8'hC8;
  localparam longint unsigned SPEED_CONST = 64'd18826345;
  localparam longint unsigned DIST_MASK = 64'hFFFF_FFFF_FFFF;

  class speed_scoreboard;
    logic [5:0]  wheel_in;
    logic [7:0]  ppr;
    logic [15:0] win_ms;
    logic [15:0] alarm_limit;
    longint unsigned ring[DEPTH];
    int unsigned ring_pos;
    logic [15:0] shown;
    logic [47:0] trip_total;
    logic [31:0] alarm_total;
    out_item_t   expected_q[$];
    int          errors;

    function void clear_state();
      wheel_in = WHEEL_RST;
      ppr = PPR_RST;
      win_ms = WIN_RST;
      alarm_limit = LIM_RST;
      foreach (ring[i]) ring[i] = 0;
      ring_pos = 0;
      shown = 0;
      trip_total = 0;
      alarm_total = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_item_t c);
      case (c.index)
        REG_WHEEL_INCHES:      wheel_in = c.data[5:0];
        REG_PULSES_PER_TURN:   ppr = c.data[7:0];
        REG_WINDOW_MS:         win_ms = c.data;
        REG_ALARM_PULSE_LIMIT: alarm_limit = c.data;
        default: ;
      endcase
    endfunction

    // Works out the result of one accepted window and queues it.
    function void note_window(in_item_t it);
      longint unsigned div, raw, s1, s2, mn, mx, chosen, sh, t;
      out_item_t r;
      r = '0;
      if (it.pulse_count > PULSE_VALID_MIN) begin
        div = longint'(ppr == 0 ? 8'd1 : ppr) * longint'(win_ms == 0 ? 16'd1 : win_ms) * 256;
        raw = (longint'(it.pulse_count) * longint'(wheel_in) * SPEED_CONST) / div;
        if (raw > 64'hFF_FFFF) raw = 64'hFF_FFFF;
        ring[ring_pos] = raw;
        ring_pos = (ring_pos + 1 >= DEPTH) ? 0 : ring_pos + 1;
        s1 = 0;
        s2 = 0;
        mn = ring[0];
        mx = ring[0];
        foreach (ring[i]) begin
          s1 += ring[i];
          s2 += ring[i] * ring[i];
          if (ring[i] < mn) mn = ring[i];
          if (ring[i] > mx) mx = ring[i];
        end
        if (DEPTH * s2 - s1 * s1 <= DEPTH * DEPTH * 65536) chosen = (s1 - mn - mx) / (DEPTH - 2);
        else chosen = raw;
        sh = (chosen * 10) >> 8;
        shown = (sh > 64'hFFFF) ? 16'hFFFF : sh[15:0];
        trip_total = 48'((longint'(trip_total) + chosen) & DIST_MASK);
        if (raw > ALARM_SPEED_Q8) begin
          alarm_total = 0;
          r.rotation_alarm = 1'b1;
        end
        r.detect_done = 1'b1;
      end else if (it.antitheft_armed) begin
        t = longint'(alarm_total) + it.pulse_count;
        alarm_total = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
        if (alarm_total > alarm_limit) begin
          alarm_total = 0;
          r.rotation_alarm = 1'b1;
        end
        r.detect_done = 1'b1;
      end
      r.shown_speed_x10 = shown;
      r.trip_distance = trip_total;
      expected_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.shown_speed_x10 !== e.shown_speed_x10) begin
        $error("shown_speed_x10: expected %0d, got %0d", e.shown_speed_x10, got.shown_speed_x10);
        errors++;
      end
      if (got.trip_distance !== e.trip_distance) begin
        $error("trip_distance: expected %0d, got %0d", e.trip_distance, got.trip_distance);
        errors++;
      end
      if (got.rotation_alarm !== e.rotation_alarm) begin
        $error("rotation_alarm: expected %0b, got %0b", e.rotation_alarm, got.rotation_alarm);
        errors++;
      end
      if (got.detect_done !== e.detect_done) begin
        $error("detect_done: expected %0b, got %0b", e.detect_done, got.detect_done);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_gaps;
  bit   long_hold;
  speed_scoreboard sb;

  wstmo_stream_if #(cfg_item_t) cfg_if ();
  wstmo_stream_if #(in_item_t)  win_if ();
  wstmo_stream_if #(out_item_t) res_if ();

  wheel_speed_trimmed_mean_odometer #(.WINDOW_DEPTH(DEPTH)) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if.sink),
    .in_i  (win_if.sink),
    .out_o (res_if.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic write_cfg(logic [7:0] idx, logic [15:0] val);
    cfg_item_t c;
    c.index = idx;
    c.data = val;
    @(negedge clk);
    cfg_if.data <= c;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(c);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Offers one window; valid stays high across back-to-back items.
  task automatic send_window(logic [15:0] pulses, logic armed);
    in_item_t it;
    int gap;
    it.pulse_count = pulses;
    it.antitheft_armed = armed;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      win_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    win_if.data <= it;
    win_if.valid <= 1'b1;
    do @(posedge clk); while (!win_if.ready);
    sb.note_window(it);
  endtask

  task automatic drain();
    @(negedge clk);
    win_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_all(logic [15:0] w, logic [15:0] p, logic [15:0] ms, logic [15:0] lim);
    write_cfg(REG_WHEEL_INCHES, w);
    write_cfg(REG_PULSES_PER_TURN, p);
    write_cfg(REG_WINDOW_MS, ms);
    write_cfg(REG_ALARM_PULSE_LIMIT, lim);
  endtask

  // Mostly steady runs so the trimmed mean path is taken, plus noise and armed trickles.
  task automatic random_windows(int count);
    int n, kind, run;
    logic [15:0] base;
    n = 0;
    while (n < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        base = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(5, 300));
        if (base < 5) base = 5;
        run = $urandom_range(8, 14);
        repeat (run) begin
          send_window(($urandom_range(0, 3) == 0 && base < 16'hFFFF) ? base + 16'd1 : base,
                      1'($urandom_range(0, 1)));
          n++;
        end
      end else if (kind < 7) begin
        send_window(16'($urandom), 1'($urandom_range(0, 1)));
        n++;
      end else begin
        repeat ($urandom_range(2, 8)) begin
          send_window(16'($urandom_range(0, 4)), $urandom_range(0, 3) != 0);
          n++;
        end
      end
    end
  endtask

  initial begin
    out_item_t got;
    int stall;
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        res_if.ready <= 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 16);
        if (stall > 0) begin
          res_if.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      got = res_if.data;
      sb.check_result(got);
    end
  end

  initial begin
    sb = new();
    sb.clear_state();
    rst_n = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    win_if.valid = 1'b0;
    win_if.data = '0;
    no_gaps = 1'b0;
    long_hold = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset settings, idle, armed trickle crossing the limit, extremes
    send_window(16'd0, 1'b0);
    send_window(16'd4, 1'b0);
    send_window(16'd4, 1'b1);
    send_window(16'd4, 1'b1);
    send_window(16'd3, 1'b1);
    send_window(16'd0, 1'b1);
    send_window(16'd5, 1'b0);
    send_window(16'd5, 1'b1);
    repeat (7) send_window(16'd40, 1'b0);
    send_window(16'hFFFF, 1'b1);
    send_window(16'd1, 1'b1);
    drain();
    write_cfg(UNUSED_REG_INDEX, 16'hFFFF);
    // zero divisors act as one; fastest wheel saturates the raw speed
    set_all(16'hFFFF, 16'd0, 16'd0, 16'd0);
    send_window(16'hFFFF, 1'b0);
    send_window(16'd1, 1'b1);
    repeat (6) send_window(16'd5, 1'b1);
    send_window(16'd2, 1'b1);
    drain();
    set_all(16'd63, 16'd255, 16'hFFFF, 16'hFFFF);
    send_window(16'hFFFF, 1'b1);
    repeat (3) send_window(16'd4, 1'b1);
    send_window(16'd5, 1'b0);
    drain();

    // random phases across settings
    set_all(16'd14, 16'd1, 16'd500, 16'd10);
    random_windows(160);
    drain();
    set_all(16'd26, 16'd4, 16'd1000, 16'd0);
    no_gaps = 1'b1;
    random_windows(140);
    no_gaps = 1'b0;
    drain();
    set_all(16'd1, 16'd255, 16'hFFFF, 16'hFFFF);
    long_hold = 1'b1;
    random_windows(140);
    drain();
    set_all(16'd63, 16'd1, 16'd1, 16'd3);
    random_windows(140);
    drain();
    set_all(16'($urandom_range(1, 63)), 16'($urandom_range(1, 255)),
            16'($urandom_range(100, 5000)), 16'($urandom_range(0, 40)));
    long_hold = 1'b1;
    random_windows(160);
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
